// ===== hw/rtl/xorshift_range_generator_defines.svh =====
// Assertion macros shared by the checker of the xorshift range generator.
`ifndef XORSHIFT_RANGE_GENERATOR_DEFINES_SVH
`define XORSHIFT_RANGE_GENERATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define XRG_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define XRG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== hw/rtl/xrg_pkg.sv =====
// Shared constants, types and the xorshift step function of the range generator.
package xrg_pkg;

    localparam int WORD_W  = 32;
    localparam int CNT_W   = $clog2(WORD_W);
    localparam int SHIFT_A = 11;
    localparam int SHIFT_B = 16;
    localparam int SHIFT_C = 5;
    localparam logic [WORD_W-1:0] SEED = 32'd42;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [WORD_W-1:0] xs_advance(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] t;
        t = w ^ (w << SHIFT_A);
        t = t ^ (t >> SHIFT_B);
        t = t ^ (t << SHIFT_C);
        return t;
    endfunction

endpackage

// ===== hw/rtl/xrg_front.sv =====
// Front end: accepts request items, orders the bounds and forms the range span.
module xrg_front #(
    parameter int BOUND_BITS = 16
) (
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [BOUND_BITS-1:0] bound_a,
    input  logic signed [BOUND_BITS-1:0] bound_b,
    input  xrg_pkg::q_status_t           q_status,
    output logic                         push,
    output logic [2*BOUND_BITS:0]        push_data
);

    logic signed [BOUND_BITS:0] a_x;
    logic signed [BOUND_BITS:0] b_x;
    logic signed [BOUND_BITS:0] lo_x;
    logic signed [BOUND_BITS:0] hi_x;
    logic                       swap;
    logic [BOUND_BITS:0]        diff;
    logic [BOUND_BITS:0]        span;

    always_comb
    begin
        a_x  = {bound_a[BOUND_BITS-1], bound_a};
        b_x  = {bound_b[BOUND_BITS-1], bound_b};
        swap = a_x > b_x;
        lo_x = swap ? b_x : a_x;
        hi_x = swap ? a_x : b_x;
        diff = unsigned'(hi_x - lo_x);
        span = diff + (BOUND_BITS+1)'(1);
    end

    assign in_stall  = q_status.full;
    assign push      = in_valid && !q_status.full;
    assign push_data = {lo_x[BOUND_BITS-1:0], span};

endmodule

// ===== hw/rtl/xrg_queue.sv =====
// Two-entry queue between the front end and the modulo back end.
module xrg_queue #(
    parameter int DATA_W = 33
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic [DATA_W-1:0]  push_data,
    input  logic               pop,
    output logic [DATA_W-1:0]  pop_data,
    output xrg_pkg::q_status_t q_status
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data       = mem[rd_ptr_reg];
    assign q_status.full  = (count_reg == CNT_W'(DEPTH));
    assign q_status.empty = (count_reg == '0);

endmodule

// ===== hw/rtl/xrg_back.sv =====
// Back end: xorshift step, bit-serial modulo by the span, and the result register.
module xrg_back #(
    parameter int BOUND_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  xrg_pkg::q_status_t                  q_status,
    input  logic [2*BOUND_BITS:0]               pop_data,
    output logic                                pop,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [BOUND_BITS-1:0]        value,
    output logic [xrg_pkg::WORD_W-1:0]          raw_word
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]                  state_reg;
    logic [1:0]                  state_next;
    logic [xrg_pkg::CNT_W-1:0]   cnt_reg;
    logic [xrg_pkg::CNT_W-1:0]   cnt_next;
    logic [xrg_pkg::WORD_W-1:0]  word_reg;
    logic [xrg_pkg::WORD_W-1:0]  word_next;
    logic [xrg_pkg::WORD_W-1:0]  div_reg;
    logic [xrg_pkg::WORD_W-1:0]  div_next;
    logic [BOUND_BITS-1:0]       rem_reg;
    logic [BOUND_BITS-1:0]       rem_next;
    logic [BOUND_BITS-1:0]       lo_reg;
    logic [BOUND_BITS-1:0]       lo_next;
    logic [BOUND_BITS:0]         span_reg;
    logic [BOUND_BITS:0]         span_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [BOUND_BITS-1:0]       value_reg;
    logic [BOUND_BITS-1:0]       value_next;
    logic [xrg_pkg::WORD_W-1:0]  raw_reg;
    logic [xrg_pkg::WORD_W-1:0]  raw_next;

    logic [xrg_pkg::WORD_W-1:0]  adv_word;
    logic [BOUND_BITS:0]         step_t;
    logic [BOUND_BITS:0]         step_sub;
    logic                        out_free;

    always_comb
    begin
        adv_word = xrg_pkg::xs_advance(word_reg);
        step_t   = {rem_reg, div_reg[xrg_pkg::WORD_W-1]};
        step_sub = (step_t >= span_reg) ? (step_t - span_reg) : step_t;
        out_free = !out_valid_reg || !out_stall;
        pop      = (state_reg == ST_IDLE) && !q_status.empty;

        state_next     = state_reg;
        cnt_next       = cnt_reg;
        word_next      = word_reg;
        div_next       = div_reg;
        rem_next       = rem_reg;
        lo_next        = lo_reg;
        span_next      = span_reg;
        out_valid_next = out_valid_reg && out_stall;
        value_next     = value_reg;
        raw_next       = raw_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    word_next  = adv_word;
                    div_next   = adv_word;
                    rem_next   = '0;
                    cnt_next   = '0;
                    lo_next    = pop_data[2*BOUND_BITS:BOUND_BITS+1];
                    span_next  = pop_data[BOUND_BITS:0];
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                div_next = div_reg << 1;
                rem_next = step_sub[BOUND_BITS-1:0];
                cnt_next = cnt_reg + xrg_pkg::CNT_W'(1);
                if (cnt_reg == xrg_pkg::CNT_W'(xrg_pkg::WORD_W - 1))
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    value_next     = lo_reg + rem_reg;
                    raw_next       = word_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            word_reg      <= xrg_pkg::SEED;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            word_reg      <= word_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg   <= div_next;
        rem_reg   <= rem_next;
        lo_reg    <= lo_next;
        span_reg  <= span_next;
        value_reg <= value_next;
        raw_reg   <= raw_next;
    end

    assign out_valid = out_valid_reg;
    assign value     = signed'(value_reg);
    assign raw_word  = raw_reg;

endmodule

// ===== hw/rtl/xorshift_range_generator.sv =====
// Items pass the two-entry queue, the one-bit-per-cycle modulo loop over the 32-bit
// word and the result register; the back end pops a new item only once it is idle,
// but the queue lets two further items be taken meanwhile.
// Reset (rst_n low, asynchronous) empties the queue, drops any pending result
// and sets the generator word to 42; there is no clearing pass.
module xorshift_range_generator #(
    parameter int BOUND_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [BOUND_BITS-1:0] bound_a,
    input  logic signed [BOUND_BITS-1:0] bound_b,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [BOUND_BITS-1:0] value,
    output logic [xrg_pkg::WORD_W-1:0]   raw_word
);

    localparam int Q_W = 2 * BOUND_BITS + 1;

    xrg_pkg::q_status_t q_status;
    logic               push;
    logic               pop;
    logic [Q_W-1:0]     push_data;
    logic [Q_W-1:0]     pop_data;

    xrg_front #(
        .BOUND_BITS(BOUND_BITS)
    ) u_front (
        .in_valid (in_valid),
        .in_stall (in_stall),
        .bound_a  (bound_a),
        .bound_b  (bound_b),
        .q_status (q_status),
        .push     (push),
        .push_data(push_data)
    );

    xrg_queue #(
        .DATA_W(Q_W)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_data(push_data),
        .pop      (pop),
        .pop_data (pop_data),
        .q_status (q_status)
    );

    xrg_back #(
        .BOUND_BITS(BOUND_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .pop_data (pop_data),
        .pop      (pop),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .value    (value),
        .raw_word (raw_word)
    );

endmodule

// ===== hw/rtl/xrg_checker.sv =====
// Port-level checker for the xorshift range generator and its bind.
`include "xorshift_range_generator_defines.svh"

module xrg_checker #(
    parameter int BOUND_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic signed [BOUND_BITS-1:0] value,
    input  logic [xrg_pkg::WORD_W-1:0]   raw_word
);

    localparam logic [2:0] MAX_PENDING = 3'd4;

    logic [2:0] pend_reg;
    logic [2:0] pend_next;
    logic       in_acc;
    logic       out_acc;

    always_comb
    begin
        in_acc    = in_valid && !in_stall;
        out_acc   = out_valid && !out_stall;
        pend_next = pend_reg;
        if (in_acc && !out_acc)
        begin
            pend_next = pend_reg + 3'd1;
        end
        else if (out_acc && !in_acc)
        begin
            pend_next = pend_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    `XRG_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
    `XRG_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(value) && $stable(raw_word))
    `XRG_ASSERT_IMPL(a_out_has_item, out_valid, pend_reg != 3'd0 && pend_reg <= MAX_PENDING)
    `XRG_ASSERT_IMPL(a_word_nonzero, out_valid, raw_word != '0)

endmodule

bind xorshift_range_generator xrg_checker #(
    .BOUND_BITS(BOUND_BITS)
) u_xrg_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .value    (value),
    .raw_word (raw_word)
);

// ===== bench/testbench.sv =====
// Self-checking testbench for the xorshift range generator: directed bounds, random bounds, idling and backpressure.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BOUND_BITS   = 16;
    localparam int WORD_W       = xrg_pkg::WORD_W;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_CYCLES = 50;

    typedef struct {
        logic signed [BOUND_BITS-1:0] value;
        logic [WORD_W-1:0]            raw;
    } range_result_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_stall;
    logic signed [BOUND_BITS-1:0] bound_a = '0;
    logic signed [BOUND_BITS-1:0] bound_b = '0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic signed [BOUND_BITS-1:0] value;
    logic [WORD_W-1:0]            raw_word;

    range_result_t     pending_results[$];
    logic [WORD_W-1:0] generator_word = xrg_pkg::SEED;
    int                mismatches = 0;
    int                cycles = 0;
    int                sender_idle_pct = 0;
    int                receiver_stall_pct = 0;
    int                hold_request = 0;
    int                hold_left = 0;

    xorshift_range_generator #(
        .BOUND_BITS(BOUND_BITS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .bound_a  (bound_a),
        .bound_b  (bound_b),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .value    (value),
        .raw_word (raw_word)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic logic [WORD_W-1:0] step_xorshift(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] t;
        t = w ^ (w << 11);
        t = t ^ (t >> 16);
        t = t ^ (t << 5);
        return t;
    endfunction

    function automatic range_result_t predict_range_value(
        input logic signed [BOUND_BITS-1:0] a,
        input logic signed [BOUND_BITS-1:0] b
    );
        range_result_t r;
        longint        lo;
        longint        hi;
        longint        tmp;
        longint        span;
        longint        rem;
        longint        v;
        lo = a;
        hi = b;
        if (lo > hi)
        begin
            tmp = lo;
            lo  = hi;
            hi  = tmp;
        end
        span = hi - lo + 1;
        generator_word = step_xorshift(generator_word);
        rem = longint'({32'd0, generator_word}) % span;
        v = lo + rem;
        r.value = v[BOUND_BITS-1:0];
        r.raw   = generator_word;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at cycle %0d: %s", cycles, msg);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // hold off for a requested stretch, otherwise stall at random
    always @(posedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
            out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    always @(posedge clk)
    begin
        range_result_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                report_mismatch($sformatf("unexpected result value=%0d raw=%08h",
                                          value, raw_word));
            else
            begin
                exp_r = pending_results.pop_front();
                if (value !== exp_r.value)
                    report_mismatch($sformatf("value %0d, expected %0d",
                                              value, exp_r.value));
                if (raw_word !== exp_r.raw)
                    report_mismatch($sformatf("raw_word %08h, expected %08h",
                                              raw_word, exp_r.raw));
            end
        end
    end

    task automatic send_bounds(input logic signed [BOUND_BITS-1:0] a,
                               input logic signed [BOUND_BITS-1:0] b);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        bound_a  <= a;
        bound_b  <= b;
        do
            @(posedge clk);
        while (in_stall);
        pending_results.push_back(predict_range_value(a, b));
    endtask

    task automatic wait_all_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic pick_bounds(output logic signed [BOUND_BITS-1:0] a,
                               output logic signed [BOUND_BITS-1:0] b);
        a = BOUND_BITS'($urandom);
        case ($urandom_range(5))
            0: b = BOUND_BITS'($urandom);
            1: b = a + BOUND_BITS'($urandom_range(0, 64)) - BOUND_BITS'(32);
            2: b = a;
            3: b = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            default:
            begin
                a = BOUND_BITS'($urandom_range(0, 40)) - BOUND_BITS'(20);
                b = BOUND_BITS'($urandom_range(0, 40)) - BOUND_BITS'(20);
            end
        endcase
    endtask

    task automatic run_random(input int count, input int idle_pct, input int stall_pct);
        logic signed [BOUND_BITS-1:0] a;
        logic signed [BOUND_BITS-1:0] b;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        for (int i = 0; i < count; i++)
        begin
            pick_bounds(a, b);
            send_bounds(a, b);
        end
        wait_all_results();
    endtask

    task automatic test_directed_bounds();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        send_bounds(16'sh8000, 16'sh7fff);
        send_bounds(16'sh7fff, 16'sh8000);
        send_bounds(16'sh0000, 16'sh0000);
        send_bounds(16'sh8000, 16'sh8000);
        send_bounds(16'sh7fff, 16'sh7fff);
        send_bounds(16'shffff, 16'shffff);
        send_bounds(16'sd100, -16'sd100);
        send_bounds(-16'sd100, 16'sd100);
        send_bounds(16'sd5, 16'sd6);
        send_bounds(16'sd6, 16'sd5);
        send_bounds(-16'sd1, 16'sd0);
        send_bounds(16'sh5555, 16'shaaaa);
        send_bounds(16'shaaaa, 16'sh5555);
        send_bounds(16'sh8000, 16'sh8001);
        send_bounds(16'sh7ffe, 16'sh7fff);
        send_bounds(16'sh0000, 16'sh7fff);
        send_bounds(16'sh8000, 16'shffff);
        send_bounds(16'sd1, 16'sd2);
        send_bounds(16'sd0, 16'sd255);
        send_bounds(16'sh8000, 16'sh0000);
        wait_all_results();
    endtask

    task automatic test_random_no_idle();
        run_random(120, 0, 0);
    endtask

    task automatic test_random_sender_idle();
        run_random(100, 71, 0);
    endtask

    task automatic test_random_receiver_stall();
        run_random(100, 0, 71);
    endtask

    task automatic test_random_both_idle();
        run_random(100, 9, 9);
    endtask

    task automatic test_backpressure();
        logic signed [BOUND_BITS-1:0] a;
        logic signed [BOUND_BITS-1:0] b;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_request = 400;
        for (int i = 0; i < 12; i++)
        begin
            pick_bounds(a, b);
            send_bounds(a, b);
        end
        wait_all_results();
    endtask

    task automatic test_pause_between_bursts();
        logic signed [BOUND_BITS-1:0] a;
        logic signed [BOUND_BITS-1:0] b;
        sender_idle_pct    = 0;
        receiver_stall_pct = 30;
        for (int burst = 0; burst < 3; burst++)
        begin
            for (int i = 0; i < 5; i++)
            begin
                pick_bounds(a, b);
                send_bounds(a, b);
            end
            wait_all_results();
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_bounds();
        test_random_no_idle();
        test_random_sender_idle();
        test_random_receiver_stall();
        test_random_both_idle();
        test_backpressure();
        test_pause_between_bursts();
        receiver_stall_pct = 0;
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
